>>> rtl/mlfq_thread_scheduler_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the scheduler
// Shared property forms, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef MLFQ_THREAD_SCHEDULER_TOP_ASSERT_SVH
`define MLFQ_THREAD_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication
`define MLFQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MLFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mlfq_pkg.sv
// ---------------------------------------------------------------------------
// mlfq_pkg
// Constants and controller/datapath interface types of the scheduler.
// ---------------------------------------------------------------------------
package mlfq_pkg;

    localparam int MAX_THREADS = 64;
    localparam int LEVELS      = 10;
    localparam int CLASSES     = 4;
    localparam int TIME_BITS   = 16;
    localparam int NUM_LISTS   = LEVELS * CLASSES;

    localparam int ID_W    = $clog2(MAX_THREADS);
    localparam int LVL_W   = 4;
    localparam int PC_W    = 2;
    localparam int Q_W     = $clog2(NUM_LISTS);
    localparam int CNT_W   = $clog2(MAX_THREADS + 1);
    localparam int SLICE_W = 10;

    localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(LEVELS - 1);

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // latch the incoming item, start reads
        logic add_eval;    // demotion check, thread record write
        logic add_reject;  // thread already waiting: report it unchanged
        logic add_commit;  // link into list, report placement
        logic sel_commit;  // unlink head, charge burst, report
        logic sel_empty;   // nothing ready: report zeros
    } mlfq_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic found;       // some list is non-empty
        logic waiting_hit; // thread of the current add is already queued
        logic out_free;    // output register can take a result
    } mlfq_stat_t;

endpackage

>>> rtl/mlfq_thread_scheduler_top.sv
// ---------------------------------------------------------------------------
// mlfq_thread_scheduler_top
// Multilevel feedback queue scheduler: add threads, select the next one.
// ---------------------------------------------------------------------------
// One item is worked at a time. An add places its result in the output
// register after a record update with demotion check and tail read, then a
// list link; a select after a record and link read, then an unlink. A select
// with every list empty reports zeros, and an add whose thread is already
// waiting reports its record unchanged and is not linked. The next item can
// be accepted on the edge following that result. The steps are set by the
// registered single-port reads of the thread record and list memories.
// in_stall is high from acceptance until the result enters the output
// register; a result held by out_stall delays completion of the next item.
// Reset needs no clearing pass: list occupancy and thread waiting flags are
// flip-flops cleared at once.
module mlfq_thread_scheduler_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [mlfq_pkg::ID_W-1:0]             thread_id,
    input  logic [mlfq_pkg::PC_W-1:0]             priority_class,
    input  logic [mlfq_pkg::TIME_BITS-1:0]        next_burst,
    input  logic                                  first_arrival,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  thread_valid,
    output logic [mlfq_pkg::ID_W-1:0]             chosen_thread,
    output logic [mlfq_pkg::LVL_W-1:0]            queue_level,
    output logic [mlfq_pkg::PC_W-1:0]             chosen_priority,
    output logic [mlfq_pkg::SLICE_W-1:0]          slice_ticks,
    output logic [mlfq_pkg::CNT_W-1:0]            ready_count
);

`include "mlfq_thread_scheduler_top_assert.svh"

    mlfq_pkg::mlfq_ctrl_t ctrl;
    mlfq_pkg::mlfq_stat_t stat;

    mlfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    mlfq_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .stat            (stat),
        .command         (command),
        .thread_id       (thread_id),
        .priority_class  (priority_class),
        .next_burst      (next_burst),
        .first_arrival   (first_arrival),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .thread_valid    (thread_valid),
        .chosen_thread   (chosen_thread),
        .queue_level     (queue_level),
        .chosen_priority (chosen_priority),
        .slice_ticks     (slice_ticks),
        .ready_count     (ready_count)
    );

    // Checks
    `MLFQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
    `MLFQ_ASSERT_NOW(a_slice_on_select, out_valid && thread_valid, slice_ticks != '0, "select without slice")
    `MLFQ_ASSERT_NOW(a_no_slice_else, out_valid && !thread_valid, slice_ticks == '0, "slice without select")
    `MLFQ_ASSERT_NOW(a_count_bound, out_valid, ready_count <= mlfq_pkg::CNT_W'(mlfq_pkg::MAX_THREADS), "ready count overflow")

endmodule

>>> rtl/mlfq_ctrl.sv
// ---------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer for add and select items.
// ---------------------------------------------------------------------------
module mlfq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  mlfq_pkg::mlfq_stat_t stat,
    output mlfq_pkg::mlfq_ctrl_t ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_EVAL,
        ST_ADD_LINK,
        ST_SEL_READ,
        ST_SEL_DONE,
        ST_SEL_EMPTY
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    // Command decode
    always_comb
    begin
        ctrl            = '0;
        ctrl.accept     = (state_reg == ST_IDLE) && in_valid;
        ctrl.add_eval   = (state_reg == ST_ADD_EVAL) && !stat.waiting_hit;
        ctrl.add_reject = (state_reg == ST_ADD_EVAL) && stat.waiting_hit && stat.out_free;
        ctrl.add_commit = (state_reg == ST_ADD_LINK) && stat.out_free;
        ctrl.sel_commit = (state_reg == ST_SEL_DONE) && stat.out_free;
        ctrl.sel_empty  = (state_reg == ST_SEL_EMPTY) && stat.out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == mlfq_pkg::CMD_ADD)
                        state_next = ST_ADD_EVAL;
                    else if (stat.found)
                        state_next = ST_SEL_READ;
                    else
                        state_next = ST_SEL_EMPTY;
                end
            end
            ST_ADD_EVAL:
            begin
                if (!stat.waiting_hit)
                    state_next = ST_ADD_LINK;
                else if (stat.out_free)
                    state_next = ST_IDLE;
            end
            ST_ADD_LINK:  if (stat.out_free) state_next = ST_IDLE;
            ST_SEL_READ:  state_next = ST_SEL_DONE;
            ST_SEL_DONE:  if (stat.out_free) state_next = ST_IDLE;
            ST_SEL_EMPTY: if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/mlfq_datapath.sv
// ---------------------------------------------------------------------------
// mlfq_datapath
// Thread records, linked ready lists, occupancy flags and result register.
// ---------------------------------------------------------------------------
module mlfq_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mlfq_pkg::mlfq_ctrl_t                  ctrl,
    output mlfq_pkg::mlfq_stat_t                  stat,
    input  logic                                  command,
    input  logic [mlfq_pkg::ID_W-1:0]             thread_id,
    input  logic [mlfq_pkg::PC_W-1:0]             priority_class,
    input  logic [mlfq_pkg::TIME_BITS-1:0]        next_burst,
    input  logic                                  first_arrival,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  thread_valid,
    output logic [mlfq_pkg::ID_W-1:0]             chosen_thread,
    output logic [mlfq_pkg::LVL_W-1:0]            queue_level,
    output logic [mlfq_pkg::PC_W-1:0]             chosen_priority,
    output logic [mlfq_pkg::SLICE_W-1:0]          slice_ticks,
    output logic [mlfq_pkg::CNT_W-1:0]            ready_count
);

    localparam int ID_W  = mlfq_pkg::ID_W;
    localparam int LVL_W = mlfq_pkg::LVL_W;
    localparam int PC_W  = mlfq_pkg::PC_W;
    localparam int Q_W   = mlfq_pkg::Q_W;
    localparam int TB    = mlfq_pkg::TIME_BITS;
    localparam int CNT_W = mlfq_pkg::CNT_W;
    localparam int SL_W  = mlfq_pkg::SLICE_W;
    localparam int NT    = mlfq_pkg::MAX_THREADS;
    localparam int NL    = mlfq_pkg::NUM_LISTS;

    // Memories
    logic [LVL_W-1:0] level_mem [NT];
    logic [TB-1:0]    used_mem  [NT];
    logic [PC_W-1:0]  prio_mem  [NT];
    logic [TB-1:0]    burst_mem [NT];
    logic [ID_W-1:0]  link_mem  [NT];
    logic [ID_W-1:0]  head_mem  [NL];
    logic [ID_W-1:0]  tail_mem  [NL];

    // Flags and counters
    logic [NT-1:0]    waiting_reg;
    logic [NL-1:0]    nonempty_reg;
    logic [CNT_W-1:0] total_reg;

    // Latched item and working registers
    logic [ID_W-1:0]  id_reg;
    logic [PC_W-1:0]  pc_reg;
    logic [TB-1:0]    burst_reg;
    logic             first_reg;
    logic             sel_reg;
    logic [Q_W-1:0]   q_reg;
    logic [LVL_W-1:0] lvl_reg;

    // Registered read data
    logic [LVL_W-1:0] level_rd;
    logic [TB-1:0]    used_rd;
    logic [PC_W-1:0]  prio_rd;
    logic [TB-1:0]    burst_rd;
    logic [ID_W-1:0]  link_rd;
    logic [ID_W-1:0]  head_rd;
    logic [ID_W-1:0]  tail_rd;

    // Output register
    logic             out_valid_reg;
    logic             tv_reg;
    logic [ID_W-1:0]  id_out_reg;
    logic [LVL_W-1:0] lvl_out_reg;
    logic [PC_W-1:0]  pc_out_reg;
    logic [SL_W-1:0]  slice_out_reg;
    logic [CNT_W-1:0] cnt_out_reg;

    logic             found;
    logic [Q_W-1:0]   q_enc;
    logic [LVL_W-1:0] lv_raw;
    logic [LVL_W-1:0] lv_clip;
    logic [TB-1:0]    used_cur;
    logic             demote;
    logic [LVL_W-1:0] lv_new;
    logic [Q_W-1:0]   q_calc;
    logic [ID_W-1:0]  thr_addr;
    logic [Q_W-1:0]   hq_addr;
    logic [Q_W-1:0]   tq_addr;
    logic [TB:0]      used_sum;
    logic [TB-1:0]    used_sat;
    logic [LVL_W-1:0] sel_lvl;
    logic             out_free;
    logic             emit;

    // Lowest non-empty list: lowest level first, then lowest class
    always_comb
    begin
        found = 1'b0;
        q_enc = '0;
        for (int i = NL - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                found = 1'b1;
                q_enc = Q_W'(i);
            end
        end
    end

    // Demotion check on add
    always_comb
    begin
        lv_raw   = first_reg ? '0 : level_rd;
        lv_clip  = (lv_raw > mlfq_pkg::LAST_LEVEL) ? mlfq_pkg::LAST_LEVEL : lv_raw;
        used_cur = first_reg ? '0 : used_rd;
        demote   = (used_cur >= (TB'(1) << lv_clip)) && (lv_clip != mlfq_pkg::LAST_LEVEL);
        lv_new   = lv_clip + LVL_W'(demote);
        q_calc   = Q_W'(lv_new * mlfq_pkg::CLASSES) + Q_W'(pc_reg);
    end

    // Burst charge on select, saturating
    assign used_sum = {1'b0, used_rd} + {1'b0, burst_rd};
    assign used_sat = used_sum[TB] ? {TB{1'b1}} : used_sum[TB-1:0];
    assign sel_lvl  = LVL_W'(q_reg / mlfq_pkg::CLASSES);

    // Read address selection
    assign thr_addr = ctrl.accept ? thread_id : (sel_reg ? head_rd : id_reg);
    assign hq_addr  = ctrl.accept ? q_enc : q_reg;
    assign tq_addr  = ctrl.accept ? q_enc : (ctrl.add_eval ? q_calc : q_reg);

    // Thread record memories
    always_ff @(posedge clk)
    begin
        if (ctrl.add_eval)
        begin
            level_mem[id_reg] <= lv_new;
            prio_mem[id_reg]  <= pc_reg;
            burst_mem[id_reg] <= burst_reg;
        end
        level_rd <= level_mem[thr_addr];
        prio_rd  <= prio_mem[thr_addr];
        burst_rd <= burst_mem[thr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.add_eval)
            used_mem[id_reg] <= demote ? '0 : used_cur;
        else if (ctrl.sel_commit)
            used_mem[head_rd] <= used_sat;
        used_rd <= used_mem[thr_addr];
    end

    // Link memory: cleared for a new tail, set when appending
    always_ff @(posedge clk)
    begin
        if (ctrl.add_eval)
            link_mem[id_reg] <= '0;
        else if (ctrl.add_commit && nonempty_reg[q_reg])
            link_mem[tail_rd] <= id_reg;
        link_rd <= link_mem[head_rd];
    end

    // List head and tail memories
    always_ff @(posedge clk)
    begin
        if (ctrl.add_commit && !nonempty_reg[q_reg])
            head_mem[q_reg] <= id_reg;
        else if (ctrl.sel_commit && (head_rd != tail_rd))
            head_mem[q_reg] <= link_rd;
        head_rd <= head_mem[hq_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.add_commit)
            tail_mem[q_reg] <= id_reg;
        tail_rd <= tail_mem[tq_addr];
    end

    // Item latch and working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            id_reg    <= thread_id;
            pc_reg    <= priority_class;
            burst_reg <= next_burst;
            first_reg <= first_arrival;
            sel_reg   <= (command == mlfq_pkg::CMD_SELECT);
            q_reg     <= q_enc;
        end
        else if (ctrl.add_eval)
        begin
            q_reg   <= q_calc;
            lvl_reg <= lv_new;
        end
    end

    // Occupancy flags and ready total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg  <= '0;
            nonempty_reg <= '0;
            total_reg    <= '0;
        end
        else if (ctrl.add_commit)
        begin
            waiting_reg[id_reg]  <= 1'b1;
            nonempty_reg[q_reg]  <= 1'b1;
            total_reg            <= total_reg + CNT_W'(1);
        end
        else if (ctrl.sel_commit)
        begin
            waiting_reg[head_rd] <= 1'b0;
            if (head_rd == tail_rd)
                nonempty_reg[q_reg] <= 1'b0;
            if (total_reg != '0)
                total_reg <= total_reg - CNT_W'(1);
        end
    end

    // Result register
    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = ctrl.add_reject || ctrl.add_commit || ctrl.sel_commit || ctrl.sel_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.add_reject)
        begin
            tv_reg        <= 1'b0;
            id_out_reg    <= id_reg;
            lvl_out_reg   <= level_rd;
            pc_out_reg    <= prio_rd;
            slice_out_reg <= '0;
            cnt_out_reg   <= total_reg;
        end
        else if (ctrl.add_commit)
        begin
            tv_reg        <= 1'b0;
            id_out_reg    <= id_reg;
            lvl_out_reg   <= lvl_reg;
            pc_out_reg    <= pc_reg;
            slice_out_reg <= '0;
            cnt_out_reg   <= total_reg + CNT_W'(1);
        end
        else if (ctrl.sel_commit)
        begin
            tv_reg        <= 1'b1;
            id_out_reg    <= head_rd;
            lvl_out_reg   <= sel_lvl;
            pc_out_reg    <= prio_rd;
            slice_out_reg <= SL_W'(1) << sel_lvl;
            cnt_out_reg   <= (total_reg != '0) ? total_reg - CNT_W'(1) : total_reg;
        end
        else if (ctrl.sel_empty)
        begin
            tv_reg        <= 1'b0;
            id_out_reg    <= '0;
            lvl_out_reg   <= '0;
            pc_out_reg    <= '0;
            slice_out_reg <= '0;
            cnt_out_reg   <= total_reg;
        end
    end

    assign stat.found       = found;
    assign stat.waiting_hit = waiting_reg[id_reg];
    assign stat.out_free    = out_free;

    assign out_valid       = out_valid_reg;
    assign thread_valid    = tv_reg;
    assign chosen_thread   = id_out_reg;
    assign queue_level     = lvl_out_reg;
    assign chosen_priority = pc_out_reg;
    assign slice_ticks     = slice_out_reg;
    assign ready_count     = cnt_out_reg;

endmodule
